FILE: hdl/pith_pkg.sv
// ----------------------------------------------------------------------------
// pith_pkg
// Shared constants for the point-in-triangle area test
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pith_pkg;

  // width of one coordinate field on the ports (signed q8.8)
  localparam int FIELD_BITS     = 16;
  // default internal coordinate width
  localparam int COORD_BITS_DEF = 16;
  // width of the area tolerance register
  localparam int TOL_BITS       = 16;
  // tolerance after reset
  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1;

endpackage

`default_nettype wire

FILE: hdl/pith_if.sv
// ----------------------------------------------------------------------------
// pith_if
// Valid/ready channels for queries, results and the tolerance register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pith_query_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;
  logic signed [15:0] v0_x;
  logic signed [15:0] v0_y;
  logic signed [15:0] v0_z;
  logic signed [15:0] v1_x;
  logic signed [15:0] v1_y;
  logic signed [15:0] v1_z;
  logic signed [15:0] v2_x;
  logic signed [15:0] v2_y;
  logic signed [15:0] v2_z;

  modport source (output valid, point_x, point_y, point_z, v0_x, v0_y, v0_z,
                  v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, v0_x, v0_y, v0_z,
                  v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, output ready);
endinterface

interface pith_result_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

interface pith_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] area_tolerance;

  modport source (output valid, area_tolerance, input ready);
  modport sink   (input valid, area_tolerance, output ready);
endinterface

`default_nettype wire

FILE: hdl/pith_area.sv
// ----------------------------------------------------------------------------
// pith_area
// Pipelined triangle area: floor(sqrt(|(q-p) x (r-p)|^2 / 4))
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pith_area #(
  parameter int COORD_BITS = pith_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [COORD_BITS-1:0]  p [3],
  input  wire logic signed [COORD_BITS-1:0]  q [3],
  input  wire logic signed [COORD_BITS-1:0]  r [3],
  output logic             [2*COORD_BITS:0]  area
);
  import pith_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int DW  = CB + 1;       // edge vector components
  localparam int PW  = 2 * CB + 2;   // partial products
  localparam int CRW = 2 * CB + 3;   // cross components
  localparam int MW  = 2 * CB + 2;   // cross magnitudes
  localparam int QW  = 4 * CB + 4;   // squared magnitudes
  localparam int SW  = 4 * CB + 2;   // quarter of the squared norm
  localparam int RW  = 2 * CB + 1;   // root width

  logic signed [DW-1:0]  u [3];
  logic signed [DW-1:0]  w [3];
  logic signed [PW-1:0]  m [6];
  logic signed [CRW-1:0] cr [3];
  logic        [MW-1:0]  mg [3];
  logic        [QW-1:0]  sq [3];
  logic        [QW+1:0]  sq_sum;
  logic        [SW-1:0]  op [RW+1];
  logic        [SW-1:0]  rt [RW+1];

  // edge vectors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u[i] <= DW'(q[i]) - DW'(p[i]);
        w[i] <= DW'(r[i]) - DW'(p[i]);
      end
    end
  end

  // cross product partial products
  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= PW'(u[1]) * PW'(w[2]);
      m[1] <= PW'(u[2]) * PW'(w[1]);
      m[2] <= PW'(u[2]) * PW'(w[0]);
      m[3] <= PW'(u[0]) * PW'(w[2]);
      m[4] <= PW'(u[0]) * PW'(w[1]);
      m[5] <= PW'(u[1]) * PW'(w[0]);
    end
  end

  // cross components and their magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = CRW'(m[2*i]) - CRW'(m[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mg[i] <= cr[i][CRW-1] ? MW'(-cr[i]) : MW'(cr[i]);
      end
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= QW'(mg[i]) * QW'(mg[i]);
      end
    end
  end

  // squared norm over four
  assign sq_sum = (QW+2)'(sq[0]) + (QW+2)'(sq[1]) + (QW+2)'(sq[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      op[0] <= SW'(sq_sum >> 2);
      rt[0] <= '0;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam logic [SW-1:0] ONE = {{(SW-1){1'b0}}, 1'b1} << (2 * (RW - 1 - k));
    logic [SW-1:0] trial;

    assign trial = rt[k] + ONE;

    always_ff @(posedge clk) begin
      if (en) begin
        if (op[k] >= trial) begin
          op[k+1] <= op[k] - trial;
          rt[k+1] <= (rt[k] >> 1) + ONE;
        end else begin
          op[k+1] <= op[k];
          rt[k+1] <= rt[k] >> 1;
        end
      end
    end
  end

  assign area = rt[RW][RW-1:0];

endmodule

`default_nettype wire

FILE: hdl/point_in_triangle_heron_top.sv
// ----------------------------------------------------------------------------
// point_in_triangle_heron_top
// Area-sum point-in-triangle test for 3D triangles, fully pipelined
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                   | accepted when
//  query    | in  | point_x..z, v0_x..z, v1_x..z, v2_x..z     | valid && ready
//  result   | out | inside_res                                | valid && ready
//  cfg      | in  | area_tolerance                            | valid && ready
//
//  pipeline: input register, five geometry stages, one stage per root bit,
//  sum and compare
//  one transaction enters per cycle; the whole pipeline, bubbles included,
//  holds while a result waits at the output register, so nothing is lost
//  rst clears the valid bits and sets the tolerance to 1
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_in_triangle_heron_top #(
  parameter int COORD_BITS = pith_pkg::COORD_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  pith_query_if.sink    query,
  pith_result_if.source result,
  pith_cfg_if.sink      cfg
);
  import pith_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int RW   = 2 * CB + 1;
  localparam int NSTG = 1 + 5 + RW + 2;
  localparam int SUMW = RW + 2;
  localparam int CW   = RW + TOL_BITS + 2;

  logic [NSTG-1:0]          vld;
  logic                     en;
  logic [TOL_BITS-1:0]      tol;
  logic signed [CB-1:0]     pt [3];
  logic signed [CB-1:0]     va [3];
  logic signed [CB-1:0]     vb [3];
  logic signed [CB-1:0]     vc [3];
  logic [RW-1:0]            a_s1;
  logic [RW-1:0]            a_s2;
  logic [RW-1:0]            a_s3;
  logic [RW-1:0]            a_full;
  logic [SUMW-1:0]          sub_sum;
  logic [RW-1:0]            full_q;
  logic                     in_tri;

  // pipeline advance
  assign en          = !vld[NSTG-1] || result.ready;
  assign query.ready = en;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], query.valid};
    end
  end

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg.valid && cfg.ready) begin
      tol <= cfg.area_tolerance;
    end
  end

  // input register, coordinates wrapped to the internal width
  always_ff @(posedge clk) begin
    if (en) begin
      pt[0] <= CB'(query.point_x);
      pt[1] <= CB'(query.point_y);
      pt[2] <= CB'(query.point_z);
      va[0] <= CB'(query.v0_x);
      va[1] <= CB'(query.v0_y);
      va[2] <= CB'(query.v0_z);
      vb[0] <= CB'(query.v1_x);
      vb[1] <= CB'(query.v1_y);
      vb[2] <= CB'(query.v1_z);
      vc[0] <= CB'(query.v2_x);
      vc[1] <= CB'(query.v2_y);
      vc[2] <= CB'(query.v2_z);
    end
  end

  // four area lanes
  pith_area #(.COORD_BITS(CB)) u_area_s1 (
    .clk(clk), .en(en), .p(pt), .q(va), .r(vb), .area(a_s1)
  );
  pith_area #(.COORD_BITS(CB)) u_area_s2 (
    .clk(clk), .en(en), .p(pt), .q(va), .r(vc), .area(a_s2)
  );
  pith_area #(.COORD_BITS(CB)) u_area_s3 (
    .clk(clk), .en(en), .p(vb), .q(vc), .r(pt), .area(a_s3)
  );
  pith_area #(.COORD_BITS(CB)) u_area_full (
    .clk(clk), .en(en), .p(va), .q(vb), .r(vc), .area(a_full)
  );

  // sub-area sum
  always_ff @(posedge clk) begin
    if (en) begin
      sub_sum <= SUMW'(a_s1) + SUMW'(a_s2) + SUMW'(a_s3);
      full_q  <= a_full;
    end
  end

  // sum - tol < full  is  sum < full + tol
  always_ff @(posedge clk) begin
    if (en) begin
      in_tri <= CW'(sub_sum) < (CW'(full_q) + CW'(tol));
    end
  end

  assign result.valid      = vld[NSTG-1];
  assign result.inside_res = in_tri;

endmodule

`default_nettype wire

FILE: hdl/pith_checker.sv
// ----------------------------------------------------------------------------
// pith_checker
// Port-level checks for the point-in-triangle block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pith_sva (
  input wire logic clk,
  input wire logic rst,
  input wire logic query_ready,
  input wire logic result_valid,
  input wire logic result_ready,
  input wire logic inside_res
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // an empty output stage never blocks new queries
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> query_ready)
    else $error("query blocked with empty output");

  // a stalled output blocks the input
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !query_ready)
    else $error("query taken while output stalled");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(inside_res)))
    else $error("stalled result changed");

endmodule

bind point_in_triangle_heron_top pith_sva u_pith_sva (
  .clk(clk),
  .rst(rst),
  .query_ready(query.ready),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .inside_res(result.inside_res)
);

`default_nettype wire
